>>> rtl/pcg_pkg.sv
// Shared types and constants for the PCG32 bounded random unit.
package pcg_pkg;

	localparam logic [63:0] PCG_MUL = 64'd6364136223846793005;
	localparam logic [63:0] PCG_INC = 64'd11634580027462260723;
	localparam int unsigned XS_SHIFT = 18;
	localparam int unsigned OUT_SHIFT = 27;
	localparam int unsigned ROT_SHIFT = 59;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned CNT_W = $clog2(DIV_STEPS);

	typedef enum logic [0:0] {
		OP_RAW    = 1'b0,
		OP_RANGED = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		MUL_LL = 2'd0,
		MUL_HL = 2'd1,
		MUL_LH = 2'd2
	} mul_sel_t;

	typedef enum logic [0:0] {
		DIV_SRC_ALL  = 1'b0,
		DIV_SRC_WORD = 1'b1
	} div_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_CUT,
		ST_CUTSET,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_ADV,
		ST_PERM,
		ST_CHECK,
		ST_MOD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic     cap_in;
		logic     div_init;
		div_src_t div_src;
		logic     div_step;
		logic     cut_set;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     acc_load;
		logic     acc_add;
		logic     adv;
		logic     perm;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic op_raw;
		logic rng_eq;
		logic rng_inv;
		logic word_ok;
		logic div_last;
	} status_t;

endpackage

>>> rtl/pcg_dp.sv
// Datapath: generator state, shared 32x32 multiplier, serial remainder unit, output register.
module pcg_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [63:0]       cfg_wr_data,
	input  logic [63:0]       in_data,
	input  logic              in_op,
	input  pcg_pkg::cmd_t     cmd,
	output pcg_pkg::status_t  status,
	output logic [31:0]       out_value,
	output logic              out_error
);

	logic [63:0] gen_q;
	logic [63:0] prod_q;
	logic [63:0] acc_q;
	logic [31:0] word_q;
	logic [31:0] cut_q;
	logic [31:0] min_q;
	logic [31:0] max_q;
	logic        op_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [pcg_pkg::CNT_W-1:0] cnt_q;

	logic [31:0] span;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [32:0] trial;
	logic [32:0] trial_sub;
	logic [63:0] mixed;
	logic [31:0] xs_word;
	logic [4:0]  rot;
	logic [63:0] rot_dbl;
	logic [31:0] result;

	localparam logic [31:0] MUL_LO = pcg_pkg::PCG_MUL[31:0];
	localparam logic [31:0] MUL_HI = pcg_pkg::PCG_MUL[63:32];

	assign span = max_q - min_q;

	always_comb begin
		unique case (cmd.mul_sel)
			pcg_pkg::MUL_LL: begin
				mul_a = gen_q[31:0];
				mul_b = MUL_LO;
			end
			pcg_pkg::MUL_HL: begin
				mul_a = gen_q[63:32];
				mul_b = MUL_LO;
			end
			pcg_pkg::MUL_LH: begin
				mul_a = gen_q[31:0];
				mul_b = MUL_HI;
			end
			default: begin
				mul_a = gen_q[31:0];
				mul_b = MUL_LO;
			end
		endcase
	end

	assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

	assign trial     = {rem_q, dvd_q[31]};
	assign trial_sub = trial - {1'b0, span};

	assign mixed   = ((gen_q >> pcg_pkg::XS_SHIFT) ^ gen_q) >> pcg_pkg::OUT_SHIFT;
	assign xs_word = mixed[31:0];
	assign rot     = gen_q[pcg_pkg::ROT_SHIFT +: 5];
	assign rot_dbl = {xs_word, xs_word} >> rot;

	always_comb begin
		priority if (op_q == pcg_pkg::OP_RAW) begin
			result = word_q;
		end else if (max_q <= min_q) begin
			result = min_q;
		end else begin
			result = min_q + rem_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				gen_q <= cfg_wr_data;
			end else if (cmd.adv) begin
				gen_q <= acc_q + pcg_pkg::PCG_INC;
			end
			if (cmd.div_init) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + pcg_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			op_q  <= in_op;
			min_q <= in_data[31:0];
			max_q <= in_data[63:32];
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + {prod_q[31:0], 32'd0};
		end
		if (cmd.perm) begin
			word_q <= rot_dbl[31:0];
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			dvd_q <= (cmd.div_src == pcg_pkg::DIV_SRC_WORD) ? word_q : '1;
		end else if (cmd.div_step) begin
			rem_q <= trial_sub[32] ? trial[31:0] : trial_sub[31:0];
			dvd_q <= {dvd_q[30:0], 1'b0};
		end
		if (cmd.cut_set) begin
			cut_q <= ~rem_q;
		end
		if (cmd.out_load) begin
			out_value <= result;
			out_error <= (op_q == pcg_pkg::OP_RANGED) && (max_q < min_q);
		end
	end

	assign status.op_raw   = (op_q == pcg_pkg::OP_RAW);
	assign status.rng_eq   = (max_q == min_q);
	assign status.rng_inv  = (max_q < min_q);
	assign status.word_ok  = (word_q <= cut_q);
	assign status.div_last = (cnt_q == pcg_pkg::CNT_W'(pcg_pkg::DIV_STEPS - 1));

endmodule

>>> rtl/pcg_ctrl.sv
// Controller: sequences capture, cutoff, draw, rejection, remainder and output handoff.
module pcg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  pcg_pkg::status_t  status,
	output pcg_pkg::cmd_t     cmd
);

	pcg_pkg::state_t state_q;
	pcg_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == pcg_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pcg_pkg::ST_IDLE:   if (in_valid) state_d = pcg_pkg::ST_DECODE;
			pcg_pkg::ST_DECODE: begin
				priority if (status.op_raw) begin
					state_d = pcg_pkg::ST_MUL0;
				end else if (status.rng_eq || status.rng_inv) begin
					state_d = pcg_pkg::ST_DONE;
				end else begin
					state_d = pcg_pkg::ST_CUT;
				end
			end
			pcg_pkg::ST_CUT:    if (status.div_last) state_d = pcg_pkg::ST_CUTSET;
			pcg_pkg::ST_CUTSET: state_d = pcg_pkg::ST_MUL0;
			pcg_pkg::ST_MUL0:   state_d = pcg_pkg::ST_MUL1;
			pcg_pkg::ST_MUL1:   state_d = pcg_pkg::ST_MUL2;
			pcg_pkg::ST_MUL2:   state_d = pcg_pkg::ST_MUL3;
			pcg_pkg::ST_MUL3:   state_d = pcg_pkg::ST_ADV;
			pcg_pkg::ST_ADV:    state_d = pcg_pkg::ST_PERM;
			pcg_pkg::ST_PERM:   state_d = pcg_pkg::ST_CHECK;
			pcg_pkg::ST_CHECK: begin
				priority if (status.op_raw) begin
					state_d = pcg_pkg::ST_DONE;
				end else if (status.word_ok) begin
					state_d = pcg_pkg::ST_MOD;
				end else begin
					state_d = pcg_pkg::ST_MUL0;
				end
			end
			pcg_pkg::ST_MOD:    if (status.div_last) state_d = pcg_pkg::ST_DONE;
			pcg_pkg::ST_DONE:   if (out_free) state_d = pcg_pkg::ST_IDLE;
			default:            state_d = pcg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_sel = pcg_pkg::MUL_LL;
		cmd.div_src = pcg_pkg::DIV_SRC_ALL;
		unique case (state_q)
			pcg_pkg::ST_IDLE:   cmd.cap_in = in_valid;
			pcg_pkg::ST_DECODE: cmd.div_init = 1'b1;
			pcg_pkg::ST_CUT:    cmd.div_step = 1'b1;
			pcg_pkg::ST_CUTSET: cmd.cut_set = 1'b1;
			pcg_pkg::ST_MUL0:   cmd.mul_en = 1'b1;
			pcg_pkg::ST_MUL1: begin
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = pcg_pkg::MUL_HL;
				cmd.acc_load = 1'b1;
			end
			pcg_pkg::ST_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = pcg_pkg::MUL_LH;
				cmd.acc_add = 1'b1;
			end
			pcg_pkg::ST_MUL3:   cmd.acc_add = 1'b1;
			pcg_pkg::ST_ADV:    cmd.adv = 1'b1;
			pcg_pkg::ST_PERM:   cmd.perm = 1'b1;
			pcg_pkg::ST_CHECK: begin
				cmd.div_init = 1'b1;
				cmd.div_src  = pcg_pkg::DIV_SRC_WORD;
			end
			pcg_pkg::ST_MOD:    cmd.div_step = 1'b1;
			pcg_pkg::ST_DONE:   cmd.out_load = out_free;
			default:            cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcg_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/pcg32_bounded_random_unit.sv
// Top level of the PCG32 bounded random unit.
// Raw draw: shared 32x32 multiply in states MUL0 to MUL3, then advance, permute and result load.
// Ranged: cutoff, draws repeated on rejection, result; two 32-step serial remainders dominate.
// Empty or inverted range: direct to the load. One item at a time; the next is taken in idle,
// in the cycle after the load, which waits while a previous result is stalled at the output.
// arst_n clears the controller, output valid and generator state (state 0 until a seed write).
module pcg32_bounded_random_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [63:0] cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] range_min, [63:32] range_max
	input  logic [0:0]  s_tuser,   // [0] opcode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] random_value
	output logic [0:0]  m_tuser    // [0] range_error
);

	pcg_pkg::cmd_t    cmd;
	pcg_pkg::status_t status;

	pcg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	pcg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (s_tdata),
		.in_op       (s_tuser[0]),
		.cmd         (cmd),
		.status      (status),
		.out_value   (m_tdata),
		.out_error   (m_tuser[0])
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while a draw is in progress");

	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("output valid raised without a result load");

	a_no_mul_during_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !cmd.mul_en && !cmd.adv)
		else $error("remainder step overlaps generator advance");

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the PCG32 bounded random unit: directed and random draws.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES = 400;
	localparam int RANDOM_ITEMS = 1320;
	localparam int QUIET_ITEMS = 200;

	typedef struct packed {
		logic [31:0] value;
		logic        err;
	} draw_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [63:0] cfg_wr_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic [0:0]  m_tuser;

	logic [63:0]  lcg_state;
	draw_result_t pending_draws[$];
	int           mismatches = 0;
	int           quiet_cycles = 0;
	int           hold_left = 0;
	int           rx_stall_left = 0;
	bit           tx_idle_en = 1'b1;
	bit           rx_idle_en = 1'b1;

	always #5 clk = ~clk;

	pcg32_bounded_random_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser)
	);

	function automatic logic [31:0] next_word();
		logic [63:0] s;
		logic [31:0] mixed;
		logic [4:0]  rot;
		lcg_state = lcg_state * pcg_pkg::PCG_MUL + pcg_pkg::PCG_INC;
		s = lcg_state;
		mixed = 32'(((s >> pcg_pkg::XS_SHIFT) ^ s) >> pcg_pkg::OUT_SHIFT);
		rot = 5'(s >> pcg_pkg::ROT_SHIFT);
		if (rot == 5'd0)
			return mixed;
		return (mixed >> rot) | (mixed << (6'd32 - rot));
	endfunction

	function automatic draw_result_t bounded_draw(pcg_pkg::opcode_t op, logic [31:0] lo,
		logic [31:0] hi);
		draw_result_t res;
		logic [31:0]  span;
		logic [31:0]  cutoff;
		logic [31:0]  word;
		res.err = 1'b0;
		if (op == pcg_pkg::OP_RAW) begin
			res.value = next_word();
		end else if (lo == hi) begin
			res.value = lo;
		end else if (hi < lo) begin
			res.value = lo;
			res.err = 1'b1;
		end else begin
			span = hi - lo;
			cutoff = 32'hFFFF_FFFF - (32'hFFFF_FFFF % span);
			do
				word = next_word();
			while (word > cutoff);
			res.value = lo + (word % span);
		end
		return res;
	endfunction

	// input side: seed writes and accepted draws update the predictor
	always @(posedge clk) begin
		if (!arst_n) begin
			lcg_state = '0;
		end else begin
			if (cfg_wr_en)
				lcg_state = cfg_wr_data;
			if (s_tvalid && s_tready)
				pending_draws.push_back(bounded_draw(pcg_pkg::opcode_t'(s_tuser[0]),
					s_tdata[31:0], s_tdata[63:32]));
		end
	end

	always @(posedge clk) begin
		draw_result_t exp_res;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_draws.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: value %h err %0d", m_tdata, m_tuser[0]);
			end else begin
				exp_res = pending_draws.pop_front();
				if (m_tdata !== exp_res.value || m_tuser[0] !== exp_res.err) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected value %h err %0d, got value %h err %0d",
							exp_res.value, exp_res.err, m_tdata, m_tuser[0]);
				end
			end
		end
	end

	// receiver: long hold-off on request, else random stall bursts
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_stall_left > 0) begin
			rx_stall_left--;
			m_tready <= 1'b0;
		end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
			rx_stall_left = $urandom_range(1, 10) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || cfg_wr_en || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_draw(pcg_pkg::opcode_t op, logic [31:0] lo, logic [31:0] hi);
		int gap;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {hi, lo};
		do
			@(posedge clk);
		while (!s_tready);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending_draws.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_seed(logic [63:0] seed);
		wait_idle();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= seed;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic send_random_draw();
		int          kind;
		int          span_kind;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] span;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			send_draw(pcg_pkg::OP_RAW, $urandom, $urandom);
		end else if (kind < 50) begin
			hi = $urandom_range(0, 32'hFFFF_FFFE);
			lo = $urandom_range(hi + 1, 32'hFFFF_FFFF);
			send_draw(pcg_pkg::OP_RANGED, lo, hi);
		end else if (kind < 55) begin
			lo = $urandom;
			send_draw(pcg_pkg::OP_RANGED, lo, lo);
		end else begin
			span_kind = $urandom_range(0, 9);
			if (span_kind < 4) begin
				span = $urandom_range(1, 16);
			end else if (span_kind < 7) begin
				span = $urandom;
				if (span == 0)
					span = 1;
			end else if (span_kind < 9) begin
				// spans just over half the word range reject close to half the words
				span = 32'h8000_0000 + $urandom_range(0, 1023);
			end else begin
				span = 32'hFFFF_FFFF - $urandom_range(0, 15);
			end
			lo = $urandom_range(0, 32'hFFFF_FFFF - span);
			hi = lo + span;
			send_draw(pcg_pkg::OP_RANGED, lo, hi);
		end
	endtask

	task automatic test_reset_state();
		repeat (4) send_draw(pcg_pkg::OP_RAW, 32'h0, 32'h0);
		send_draw(pcg_pkg::OP_RAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_draw(pcg_pkg::OP_RANGED, 32'h0, 32'hFFFF_FFFF);
	endtask

	task automatic test_range_corners();
		send_draw(pcg_pkg::OP_RANGED, 32'h0, 32'h0);
		send_draw(pcg_pkg::OP_RANGED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_draw(pcg_pkg::OP_RANGED, 32'h1, 32'h0);
		send_draw(pcg_pkg::OP_RANGED, 32'hFFFF_FFFF, 32'h0);
		send_draw(pcg_pkg::OP_RANGED, 32'h5, 32'h6);
		send_draw(pcg_pkg::OP_RANGED, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
		send_draw(pcg_pkg::OP_RANGED, 32'h0, 32'h8000_0001);
		send_draw(pcg_pkg::OP_RANGED, 32'h0, 32'h8000_0001);
		send_draw(pcg_pkg::OP_RANGED, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_draw(pcg_pkg::OP_RANGED, 32'h1234_5678, 32'h1234_5680);
		send_draw(pcg_pkg::OP_RAW, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
	endtask

	task automatic test_seed_extremes();
		write_seed(64'hFFFF_FFFF_FFFF_FFFF);
		send_draw(pcg_pkg::OP_RAW, 32'h0, 32'h0);
		send_draw(pcg_pkg::OP_RANGED, 32'h10, 32'h20);
		write_seed(64'h0);
		send_draw(pcg_pkg::OP_RAW, 32'h0, 32'h0);
		write_seed(64'h8000_0000_0000_0000);
		send_draw(pcg_pkg::OP_RAW, 32'h0, 32'h0);
		send_draw(pcg_pkg::OP_RANGED, 32'h0, 32'h3);
	endtask

	task automatic test_output_backpressure();
		write_seed({$urandom, $urandom});
		hold_left = HOLD_CYCLES;
		repeat (6) send_random_draw();
	endtask

	task automatic test_random_draws();
		write_seed({$urandom, $urandom});
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 300 == 299)
				write_seed({$urandom, $urandom});
			if (i == RANDOM_ITEMS - QUIET_ITEMS) begin
				tx_idle_en = 1'b0;
				rx_idle_en = 1'b0;
			end
			send_random_draw();
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_range_corners();
		test_seed_extremes();
		test_output_backpressure();
		test_random_draws();
		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_draws.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

>>> pcg32_bounded_random_unit.f
rtl/pcg_pkg.sv
rtl/pcg_dp.sv
rtl/pcg_ctrl.sv
rtl/pcg32_bounded_random_unit.sv
dv/testbench.sv
